// ===== design/lzwd_pkg.sv =====
`timescale 1ns / 1ps

package lzwd_pkg;

  // Codes below this value are literal bytes
  localparam int unsigned LIT_CODES = 256;
  localparam int unsigned BYTE_W    = 8;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_PENDING = 2'd1,
    ST_INVALID = 2'd2,
    ST_EMPTY   = 2'd3
  } status_e;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_RESP  = 6'b000010,
    S_POP   = 6'b000100,
    S_WALK  = 6'b001000,
    S_FETCH = 6'b010000,
    S_ADD   = 6'b100000
  } state_e;

endpackage

// ===== design/lzw_code_decoder_top.sv =====
`timescale 1ns / 1ps

// Fixed-width LZW code decoder. A code request expands the code into an
// output stack by walking its prefix chain through the dictionary RAM, one
// chain entry per cycle; read requests then pop the decoded string one byte
// each, first byte first. A byte read, a rejected code and a literal that
// starts a stream pass from acceptance through S_RESP, or S_POP for a
// byte, to the result register. Any other code walks its chain in S_WALK
// and S_FETCH, the single dictionary read port setting the walk rate; then
// S_ADD adds the new entry and S_RESP presents the result. One request is in
// work at a time; a stalled result holds the block. The dictionary and the
// stack have no reset and need no clearing pass.
module lzw_code_decoder_top
  import lzwd_pkg::*;
#(
  parameter int unsigned CODE_BITS = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        req_type_i,
  input  logic [11:0] code_i,
  input  logic        first_i,
  output logic        res_valid_o,
  input  logic        res_stall_i,
  output logic [1:0]  status_o,
  output logic [7:0]  out_byte_o,
  output logic        out_valid_o,
  output logic        out_last_o
);

  localparam int unsigned CW   = CODE_BITS;
  localparam int unsigned CntW = CODE_BITS + 1;
  localparam int unsigned DictDepth  = (1 << CODE_BITS) - LIT_CODES;
  localparam int unsigned StackDepth = 1 << CODE_BITS;
  localparam logic [CntW-1:0] StackFull = CntW'(StackDepth);
  localparam logic [CntW-1:0] LitCnt    = CntW'(LIT_CODES);
  localparam logic [CW-1:0]   LitCode   = CW'(LIT_CODES);

  state_e              state_q, state_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [CntW-1:0]     nf_q, nf_d;
  logic [CW-1:0]       prev_q, prev_d;
  logic [BYTE_W-1:0]   pfb_q, pfb_d;
  logic                have_q, have_d;
  logic [CW-1:0]       idx_q, idx_d;
  logic [CW-1:0]       cur_q, cur_d;
  logic [BYTE_W-1:0]   head_q, head_d;
  status_e             rst_q, rst_d;

  logic                ovld_q, ovld_d;
  status_e             ost_q, ost_d;
  logic [BYTE_W-1:0]   obyte_q, obyte_d;
  logic                oval_q, oval_d;
  logic                olast_q, olast_d;

  logic                in_acc, out_free;
  logic [CW-1:0]       code_w;
  logic                start;
  logic [CntW-1:0]     nf_wrap;
  logic [CntW-1:0]     cnt_inc;
  logic [CW-1:0]       nxt_pre;
  logic [BYTE_W-1:0]   nxt_suf;

  logic                st_we, st_re;
  logic [CW-1:0]       st_waddr, st_raddr;
  logic [BYTE_W-1:0]   st_wdata, st_rdata;
  logic                dc_we, dc_re;
  logic [CW-1:0]       dc_waddr, dc_raddr;
  logic [CW+BYTE_W-1:0] dc_wdata, dc_rdata;

  lzwd_ram #(
    .DATA_W (BYTE_W),
    .DEPTH  (StackDepth),
    .ADDR_W (CW)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .re_i    (st_re),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  lzwd_ram #(
    .DATA_W (CW + BYTE_W),
    .DEPTH  (DictDepth),
    .ADDR_W (CW)
  ) u_dict (
    .clk_i   (clk_i),
    .we_i    (dc_we),
    .waddr_i (dc_waddr),
    .wdata_i (dc_wdata),
    .re_i    (dc_re),
    .raddr_i (dc_raddr),
    .rdata_o (dc_rdata)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !ovld_q || !res_stall_i;
  assign code_w     = CW'(code_i);
  assign start      = first_i || !have_q;
  assign nf_wrap    = (nf_q == StackFull) ? LitCnt : nf_q;
  assign cnt_inc    = cnt_q + CntW'(1);
  assign nxt_pre    = dc_rdata[CW+BYTE_W-1:BYTE_W];
  assign nxt_suf    = dc_rdata[BYTE_W-1:0];

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    nf_d     = nf_q;
    prev_d   = prev_q;
    pfb_d    = pfb_q;
    have_d   = have_q;
    idx_d    = idx_q;
    cur_d    = cur_q;
    head_d   = head_q;
    rst_d    = rst_q;
    ovld_d   = ovld_q && res_stall_i;
    ost_d    = ost_q;
    obyte_d  = obyte_q;
    oval_d   = oval_q;
    olast_d  = olast_q;
    st_we    = 1'b0;
    st_waddr = cnt_q[CW-1:0];
    st_wdata = '0;
    st_re    = 1'b0;
    st_raddr = CW'(cnt_q - CntW'(1));
    dc_we    = 1'b0;
    dc_waddr = CW'(nf_wrap) - LitCode;
    dc_wdata = {prev_q, head_q};
    dc_re    = 1'b0;
    dc_raddr = idx_q - LitCode;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          rst_d   = ST_OK;
          state_d = S_RESP;
          if (req_type_i) begin
            if (cnt_q == '0) begin
              rst_d = ST_EMPTY;
            end else begin
              st_re   = 1'b1;
              cnt_d   = cnt_q - CntW'(1);
              state_d = S_POP;
            end
          end else if (cnt_q != '0) begin
            rst_d = ST_PENDING;
          end else if (start) begin
            if (code_w >= LitCode) begin
              rst_d = ST_INVALID;
            end else begin
              // literal opens a stream: restart the dictionary
              nf_d     = LitCnt;
              st_we    = 1'b1;
              st_wdata = code_w[BYTE_W-1:0];
              cnt_d    = cnt_inc;
              prev_d   = code_w;
              pfb_d    = code_w[BYTE_W-1:0];
              have_d   = 1'b1;
            end
          end else if (CntW'(code_w) > nf_q) begin
            rst_d = ST_INVALID;
          end else begin
            cur_d   = code_w;
            state_d = S_WALK;
            if (CntW'(code_w) == nf_q) begin
              // string not yet in the dictionary: previous string plus its first byte
              st_we    = 1'b1;
              st_wdata = pfb_q;
              cnt_d    = cnt_inc;
              head_d   = pfb_q;
              idx_d    = prev_q;
            end else begin
              idx_d = code_w;
            end
          end
        end
      end

      S_WALK: begin
        if (cnt_q == StackFull) begin
          state_d = S_ADD;
        end else if (idx_q < LitCode) begin
          st_we    = 1'b1;
          st_wdata = idx_q[BYTE_W-1:0];
          cnt_d    = cnt_inc;
          head_d   = idx_q[BYTE_W-1:0];
          state_d  = S_ADD;
        end else begin
          dc_re   = 1'b1;
          state_d = S_FETCH;
        end
      end

      S_FETCH: begin
        st_we    = 1'b1;
        st_wdata = nxt_suf;
        cnt_d    = cnt_inc;
        head_d   = nxt_suf;
        idx_d    = nxt_pre;
        if (cnt_inc == StackFull) begin
          state_d = S_ADD;
        end else if (nxt_pre < LitCode) begin
          state_d = S_WALK;
        end else begin
          // follow the chain without a gap cycle
          dc_re    = 1'b1;
          dc_raddr = nxt_pre - LitCode;
        end
      end

      S_ADD: begin
        dc_we   = 1'b1;
        nf_d    = nf_wrap + CntW'(1);
        prev_d  = cur_q;
        pfb_d   = head_q;
        rst_d   = ST_OK;
        state_d = S_RESP;
      end

      S_RESP: begin
        if (out_free) begin
          ovld_d  = 1'b1;
          ost_d   = rst_q;
          obyte_d = '0;
          oval_d  = 1'b0;
          olast_d = 1'b0;
          state_d = S_IDLE;
        end
      end

      S_POP: begin
        // hold the read data until the output register frees up
        if (out_free) begin
          ovld_d  = 1'b1;
          ost_d   = ST_OK;
          obyte_d = st_rdata;
          oval_d  = 1'b1;
          olast_d = (cnt_q == '0);
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      nf_q    <= LitCnt;
      prev_q  <= '0;
      pfb_q   <= '0;
      have_q  <= 1'b0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      nf_q    <= nf_d;
      prev_q  <= prev_d;
      pfb_q   <= pfb_d;
      have_q  <= have_d;
      ovld_q  <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    cur_q   <= cur_d;
    head_q  <= head_d;
    rst_q   <= rst_d;
    ost_q   <= ost_d;
    obyte_q <= obyte_d;
    oval_q  <= oval_d;
    olast_q <= olast_d;
  end

  assign res_valid_o = ovld_q;
  assign status_o    = ost_q;
  assign out_byte_o  = obyte_q;
  assign out_valid_o = oval_q;
  assign out_last_o  = olast_q;

`ifndef NO_ASSERTIONS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= StackFull)
    else $error("stack count beyond stack depth");

  a_nf_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nf_q >= LitCnt && nf_q <= StackFull)
    else $error("next free entry out of range");

  a_byte_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && out_valid_o |-> status_o == ST_OK)
    else $error("decoded byte with error status");

  a_one_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second request taken while one is in work");
`endif

endmodule

// ===== design/lzwd_ram.sv =====
`timescale 1ns / 1ps

module lzwd_ram #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = 4096,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
